/* sv/led_frame_packetizer_crc8_core_defines.svh */
// ----------------------------------------------------------------------------
// LED frame packetizer assertion macros
// Clocked property checks, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef LED_FRAME_PACKETIZER_CRC8_CORE_DEFINES_SVH
`define LED_FRAME_PACKETIZER_CRC8_CORE_DEFINES_SVH

`ifndef SYNTH

// ante true at an edge -> cons true at the same edge
`define LFP_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lfp check failed: same-cycle implication");

// ante true at an edge -> cons true at the next edge
`define LFP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lfp check failed: next-cycle implication");

`else

`define LFP_ASSERT_SAME(lbl, ante, cons)
`define LFP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* sv/lfp_pkg.sv */
// ----------------------------------------------------------------------------
// LED frame packetizer package
// Shared types, register indexes, reset values and the CRC-8 byte update.
// ----------------------------------------------------------------------------
package lfp_pkg;

   localparam int BYTE_W     = 8;
   localparam int LEN_W      = 10;
   localparam int FNUM_W     = 8;
   localparam int MAX_BYTES  = 5;
   localparam int CNT_W      = 3;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 10;

   localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;

   localparam logic [LEN_W-1:0]  LEN_RESET   = 10'd196;
   localparam logic [FNUM_W-1:0] FMAX_RESET  = 8'd60;
   localparam logic [BYTE_W-1:0] SYNC1_RESET = 8'hAA;
   localparam logic [BYTE_W-1:0] SYNC2_RESET = 8'h55;
   localparam logic [FNUM_W-1:0] FNUM_RESET  = 8'd1;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_PAYLOAD_LENGTH   = 2'd0,
      CSR_FRAME_NUMBER_MAX = 2'd1,
      CSR_SYNC_FIRST       = 2'd2,
      CSR_SYNC_SECOND      = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [LEN_W-1:0]  payload_length;
      logic [FNUM_W-1:0] frame_number_max;
      logic [BYTE_W-1:0] sync_first;
      logic [BYTE_W-1:0] sync_second;
   } cfg_type;

   // bytes of one request's packet slice, in send order from index 0
   typedef struct packed {
      logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
      logic [CNT_W-1:0]                 count;
      logic                             closes;
   } entry_type;

   // MSB-first CRC-8 update of one byte
   function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] c;
      c = crc ^ data;
      for (int b = 0; b < BYTE_W; b++) begin
         if (c[BYTE_W-1]) begin
            c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[BYTE_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

/* sv/lfp_framer.sv */
// ----------------------------------------------------------------------------
// LED frame packetizer framer
// Frame state and the combinational build of each request's packet bytes.
// ----------------------------------------------------------------------------
module lfp_framer
   import lfp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              take,
   input  logic [BYTE_W-1:0] payload_byte,
   output entry_type         entry
);

   logic [BYTE_W-1:0] crc_ff,  crc_in;
   logic [LEN_W-1:0]  pos_ff,  pos_in;
   logic [FNUM_W-1:0] fnum_ff, fnum_in;

   logic              start;
   logic              last;
   logic [LEN_W:0]    taken;
   logic [LEN_W:0]    len_eff;
   logic [BYTE_W-1:0] crc_pre;
   logic [BYTE_W-1:0] crc_pay;
   logic [BYTE_W-1:0] crc_fin;

   assign start   = (pos_ff == '0);
   assign taken   = {1'b0, pos_ff} + {{LEN_W{1'b0}}, 1'b1};
   // zero length means the full 2^LEN_W bytes
   assign len_eff = (cfg.payload_length == '0) ? {1'b1, {LEN_W{1'b0}}}
                                               : {1'b0, cfg.payload_length};
   assign last    = (taken >= len_eff);

   assign crc_pre = start ? crc8_byte(crc8_byte('0, cfg.sync_first), cfg.sync_second)
                          : crc_ff;
   assign crc_pay = crc8_byte(crc_pre, payload_byte);
   assign crc_fin = crc8_byte(crc_pay, fnum_ff);

   always_comb begin
      logic [CNT_W-1:0] k;
      entry = '0;
      k     = '0;
      if (start) begin
         entry.bytes[0] = cfg.sync_first;
         entry.bytes[1] = cfg.sync_second;
         k = CNT_W'(2);
      end
      entry.bytes[k] = payload_byte;
      k = k + CNT_W'(1);
      if (last) begin
         entry.bytes[k]              = fnum_ff;
         entry.bytes[k + CNT_W'(1)]  = crc_fin;
         k = k + CNT_W'(2);
      end
      entry.count  = k;
      entry.closes = last;
   end

   always_comb begin
      crc_in  = crc_ff;
      pos_in  = pos_ff;
      fnum_in = fnum_ff;
      if (take) begin
         if (last) begin
            crc_in  = '0;
            pos_in  = '0;
            fnum_in = (fnum_ff >= cfg.frame_number_max) ? FNUM_RESET
                                                        : fnum_ff + FNUM_W'(1);
         end else begin
            crc_in = crc_pay;
            pos_in = taken[LEN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff  <= '0;
         pos_ff  <= '0;
         fnum_ff <= FNUM_RESET;
      end else begin
         crc_ff  <= crc_in;
         pos_ff  <= pos_in;
         fnum_ff <= fnum_in;
      end
   end

endmodule

/* sv/lfp_serializer.sv */
// ----------------------------------------------------------------------------
// LED frame packetizer serializer
// Holds one packet slice and sends its bytes one per handshake.
// ----------------------------------------------------------------------------
module lfp_serializer
   import lfp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  entry_type         entry,
   output logic              free,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [BYTE_W-1:0] out_byte,
   output logic              out_last
);

   entry_type        entry_ff, entry_in;
   logic [CNT_W-1:0] idx_ff,   idx_in;
   logic             busy_ff,  busy_in;

   logic             final_byte;
   logic             pop;

   assign final_byte = (idx_ff == (entry_ff.count - CNT_W'(1)));
   assign pop        = busy_ff && out_ready;
   // slot frees up in the same cycle its last byte leaves
   assign free       = !busy_ff || (pop && final_byte);

   assign out_valid  = busy_ff;
   assign out_byte   = entry_ff.bytes[idx_ff];
   assign out_last   = entry_ff.closes && final_byte;

   always_comb begin
      entry_in = entry_ff;
      idx_in   = idx_ff;
      busy_in  = busy_ff;
      if (load) begin
         entry_in = entry;
         idx_in   = '0;
         busy_in  = 1'b1;
      end else if (pop) begin
         if (final_byte) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         idx_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         idx_ff  <= idx_in;
         busy_ff <= busy_in;
      end
   end

endmodule

/* sv/led_frame_packetizer_crc8_core.sv */
// ----------------------------------------------------------------------------
// LED frame packetizer with CRC-8 (poly 0x07)
// Wraps LED payload bytes into sync-framed packets closed by frame number and CRC.
// ----------------------------------------------------------------------------
//  channel | dir | data                      | side bits
//  req_    | in  | tdata[7:0] payload_byte   | -
//  rsp_    | out | tdata[7:0] out_byte       | tlast = frame_end (on CRC byte)
//  csr_    | in  | wdata[9:0], addr[1:0]     | we, no read-back
//
//  A request is built combinationally into 1 to 5 output bytes: 1 mid-frame, 3 at
//  frame start, 2 more at frame end (5 for one-byte frames); the single-byte rsp_
//  port then sends them one per cycle while rsp_tready is high.
//  The next request is taken in the cycle the previous one's last byte leaves.
//  Synchronous active-high reset; a stalled rsp_ holds its byte and req_tready.
// ----------------------------------------------------------------------------
`include "led_frame_packetizer_crc8_core_defines.svh"

module led_frame_packetizer_crc8_core
   import lfp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [BYTE_W-1:0]     req_tdata,   // [7:0] payload_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [BYTE_W-1:0]     rsp_tdata,   // [7:0] out_byte
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type   cfg_ff, cfg_in;
   entry_type entry;
   logic      take;
   logic      free;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_PAYLOAD_LENGTH:   cfg_in.payload_length   = csr_wdata[LEN_W-1:0];
            CSR_FRAME_NUMBER_MAX: cfg_in.frame_number_max = csr_wdata[FNUM_W-1:0];
            CSR_SYNC_FIRST:       cfg_in.sync_first       = csr_wdata[BYTE_W-1:0];
            CSR_SYNC_SECOND:      cfg_in.sync_second      = csr_wdata[BYTE_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.payload_length   <= LEN_RESET;
         cfg_ff.frame_number_max <= FMAX_RESET;
         cfg_ff.sync_first       <= SYNC1_RESET;
         cfg_ff.sync_second      <= SYNC2_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_tready = free;
   assign take       = req_tvalid && free;

   lfp_framer u_framer (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .take         (take),
      .payload_byte (req_tdata),
      .entry        (entry)
   );

   lfp_serializer u_serializer (
      .clock     (clock),
      .reset     (reset),
      .load      (take),
      .entry     (entry),
      .free      (free),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_byte  (rsp_tdata),
      .out_last  (rsp_tlast)
   );

   // a new request only lands when the held slice is gone or leaving now
   `LFP_ASSERT_SAME(a_take_drains, req_tvalid && req_tready && rsp_tvalid, rsp_tready)
   // every accepted request shows a byte on the next cycle
   `LFP_ASSERT_NEXT(a_take_shows, req_tvalid && req_tready, rsp_tvalid)
   // nothing pending right after reset
   `LFP_ASSERT_SAME(a_reset_empty, $past(reset), !rsp_tvalid && req_tready)

endmodule
